[sv/mrsr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mrsr_pkg
// Shared types, codes and the select-code decode tables for the multitap
// row-scan responder.
// ----------------------------------------------------------------------------
package mrsr_pkg;

  // words per socket in the value and mask stores
  localparam int unsigned WordsPerSocket = 16;
  localparam int unsigned WordIdxW = 4;

  // word driven for an absent or unused socket
  localparam logic [31:0] IDLE_WORD = 32'hFFFD_FFFD;

  // reset value of the timeout register
  localparam logic [9:0] TIMEOUT_RESET = 10'd288;

  // input word kinds
  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_WR_VAL = 2'd1,
    KIND_WR_MSK = 2'd2,
    KIND_FORCE  = 2'd3
  } kind_e;

  // mapping modes
  localparam logic [1:0] MODE_STD        = 2'd0;
  localparam logic [1:0] MODE_SIX_SINGLE = 2'd1;
  localparam logic [1:0] MODE_SIX_TAP    = 2'd2;
  localparam logic [1:0] MODE_UNUSED     = 2'd3;

  // configuration register indexes
  localparam logic CFG_MAP_MODE = 1'b0;
  localparam logic CFG_TIMEOUT  = 1'b1;

  // last row of a frame
  localparam logic [1:0] LAST_ROW = 2'd3;

  // select code to socket and row
  localparam logic [1:0] CODE_SOCKET [16] = '{
    2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd0,
    2'd2, 2'd3, 2'd3, 2'd0, 2'd3, 2'd0, 2'd0, 2'd3
  };
  localparam logic [1:0] CODE_ROW [16] = '{
    2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3,
    2'd3, 2'd0, 2'd1, 2'd2, 2'd2, 2'd1, 2'd0, 2'd3
  };

  // input word
  typedef struct packed {
    kind_e       kind;
    logic [3:0]  select_code;
    logic [1:0]  socket;
    logic [3:0]  word_index;
    logic [31:0] word_value;
  } in_item_t;

  // result word
  typedef struct packed {
    logic [31:0] drive_word;
    logic        drive_valid;
    logic        stall_active;
    logic        frame_done;
    logic [1:0]  frame_socket;
  } out_item_t;

  // per-item control carried alongside the store read
  typedef struct packed {
    logic       drive_valid;
    logic       use_mask;
    logic       idle;
    logic       stall_active;
    logic       frame_done;
    logic [1:0] frame_socket;
  } meta_t;

endpackage

`default_nettype wire

[sv/mrsr_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mrsr_store
// Value and mask memories with one write and one registered read per cycle.
// Per-entry valid flags make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module mrsr_store
  import mrsr_pkg::*;
#(
  parameter int unsigned Sockets = 4
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          wr_en_i,
  input  wire kind_e                                         wr_kind_i,
  input  wire logic [1:0]                                    wr_socket_i,
  input  wire logic [WordIdxW-1:0]                           wr_index_i,
  input  wire logic [31:0]                                   wr_data_i,
  input  wire logic                                          rd_en_i,
  input  wire logic [$clog2(Sockets*WordsPerSocket)-1:0]     rd_addr_i,
  output      logic [31:0]                                   rd_val_o,
  output      logic [31:0]                                   rd_msk_o
);

  localparam int unsigned Depth = Sockets * WordsPerSocket;
  localparam int unsigned AddrW = $clog2(Depth);

  logic [31:0] val_mem [Depth];
  logic [31:0] msk_mem [Depth];
  logic [Depth-1:0] val_vld_q;
  logic [Depth-1:0] msk_vld_q;
  logic [31:0] val_rd_q;
  logic [31:0] msk_rd_q;
  logic        val_rd_vld_q;
  logic        msk_rd_vld_q;

  logic [1+WordIdxW:0] wr_full;
  logic [AddrW-1:0]    wr_addr;
  logic                wr_ok;
  logic                wr_val;
  logic                wr_msk;

  // write address, writes to absent sockets dropped
  assign wr_full = {wr_socket_i, wr_index_i};
  assign wr_addr = wr_full[AddrW-1:0];
  assign wr_ok   = (32'(wr_socket_i) < Sockets);
  assign wr_val  = wr_en_i && wr_ok && (wr_kind_i == KIND_WR_VAL);
  assign wr_msk  = wr_en_i && wr_ok && (wr_kind_i == KIND_WR_MSK);

  // memory arrays
  always_ff @(posedge clk_i) begin
    if (wr_val) begin
      val_mem[wr_addr] <= wr_data_i;
    end
    if (wr_msk) begin
      msk_mem[wr_addr] <= wr_data_i;
    end
    if (rd_en_i) begin
      val_rd_q <= val_mem[rd_addr_i];
      msk_rd_q <= msk_mem[rd_addr_i];
    end
  end

  // written flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_vld_q    <= '0;
      msk_vld_q    <= '0;
      val_rd_vld_q <= 1'b0;
      msk_rd_vld_q <= 1'b0;
    end else begin
      if (wr_val) begin
        val_vld_q[wr_addr] <= 1'b1;
      end
      if (wr_msk) begin
        msk_vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en_i) begin
        val_rd_vld_q <= val_vld_q[rd_addr_i];
        msk_rd_vld_q <= msk_vld_q[rd_addr_i];
      end
    end
  end

  // unwritten entries read as zero
  assign rd_val_o = val_rd_vld_q ? val_rd_q : '0;
  assign rd_msk_o = msk_rd_vld_q ? msk_rd_q : '0;

endmodule

`default_nettype wire

[sv/mrsr_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mrsr_ctrl
// Scan state and configuration: change detection, stall timeout, socket
// banks, and the store read address for each accepted word.
// ----------------------------------------------------------------------------
module mrsr_ctrl
  import mrsr_pkg::*;
#(
  parameter int unsigned Sockets = 4,
  parameter int unsigned Banks   = 3
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      cfg_we_i,
  input  wire logic                                      cfg_index_i,
  input  wire logic [9:0]                                cfg_data_i,
  input  wire logic                                      accept_i,
  input  wire in_item_t                                  item_i,
  output      logic                                      rd_en_o,
  output      logic [$clog2(Sockets*WordsPerSocket)-1:0] rd_addr_o,
  output      meta_t                                     meta_o
);

  localparam int unsigned AddrW = $clog2(Sockets * WordsPerSocket);

  logic [1:0] mode_q;
  logic [9:0] limit_q;
  logic [1:0] bank_q [4];
  logic [3:0] last_q;
  logic       base_q;
  logic       lock_q;
  logic [9:0] count_q;

  logic [1:0] mode_d;
  logic [1:0] bank_d [4];
  logic [3:0] last_d;
  logic       base_d;
  logic       lock_d;
  logic [9:0] count_d;

  logic [1:0]          sock;
  logic [1:0]          row;
  logic [1:0]          bank;
  logic [1:0]          src;
  logic [3:0]          widx;
  logic                idle;
  logic [1+WordIdxW:0] full_addr;
  logic                is_sample;
  logic                changed;
  logic                needs_read;

  // decode the select code and pick the word
  always_comb begin
    sock = CODE_SOCKET[item_i.select_code];
    row  = CODE_ROW[item_i.select_code];
    bank = bank_q[sock];
    src  = sock;
    widx = {2'b00, row};
    idle = 1'b0;
    case (mode_q)
      MODE_SIX_SINGLE: begin
        src  = 2'd0;
        if (sock == 2'd1) begin
          widx = 4'd4 + {bank, 2'b00} + {2'b00, row};
        end else if (sock != 2'd0) begin
          idle = 1'b1;
        end
      end
      MODE_SIX_TAP: begin
        widx = 4'd4 + {bank, 2'b00} + {2'b00, row};
      end
      default: begin
        widx = {2'b00, row};
      end
    endcase
    if (32'(src) >= Sockets) begin
      idle = 1'b1;
    end
  end

  assign full_addr = {src, widx};
  assign rd_addr_o = full_addr[AddrW-1:0];

  assign is_sample  = (item_i.kind == KIND_SAMPLE);
  assign changed    = is_sample && base_q && (item_i.select_code != last_q);
  assign needs_read = changed || (item_i.kind == KIND_FORCE);
  assign rd_en_o    = accept_i && needs_read && !idle;

  // scan state update
  always_comb begin
    last_d  = last_q;
    base_d  = base_q;
    lock_d  = lock_q;
    count_d = count_q;
    bank_d  = bank_q;
    if (accept_i && is_sample) begin
      if (!base_q) begin
        base_d = 1'b1;
        last_d = item_i.select_code;
      end else if (changed) begin
        last_d  = item_i.select_code;
        lock_d  = 1'b1;
        count_d = '0;
        if (row == LAST_ROW) begin
          if (32'(bank_q[sock]) >= Banks - 1) begin
            bank_d[sock] = 2'd0;
          end else begin
            bank_d[sock] = bank_q[sock] + 2'd1;
          end
        end
      end else if (lock_q) begin
        if (count_q >= limit_q) begin
          lock_d  = 1'b0;
          count_d = '0;
        end else begin
          count_d = count_q + 10'd1;
        end
      end
    end
  end

  // control that travels with the read
  always_comb begin
    meta_o.drive_valid  = needs_read;
    meta_o.use_mask     = is_sample;
    meta_o.idle         = idle;
    meta_o.stall_active = lock_d;
    meta_o.frame_done   = changed && (row == LAST_ROW);
    meta_o.frame_socket = (changed && (row == LAST_ROW)) ? sock : 2'd0;
  end

  // mode register folds the unused code onto standard
  assign mode_d = (cfg_data_i[1:0] == MODE_UNUSED) ? MODE_STD : cfg_data_i[1:0];

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_STD;
      limit_q <= TIMEOUT_RESET;
      bank_q  <= '{default: 2'd0};
      last_q  <= '0;
      base_q  <= 1'b0;
      lock_q  <= 1'b0;
      count_q <= '0;
    end else begin
      if (cfg_we_i && (cfg_index_i == CFG_MAP_MODE)) begin
        mode_q <= mode_d;
      end
      if (cfg_we_i && (cfg_index_i == CFG_TIMEOUT)) begin
        limit_q <= cfg_data_i;
      end
      bank_q  <= bank_d;
      last_q  <= last_d;
      base_q  <= base_d;
      lock_q  <= lock_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

[sv/multitap_row_scan_responder_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// multitap_row_scan_responder_top
// Row-scan responder: one input word per cycle while not stalled, one result word per input.
// ----------------------------------------------------------------------------
// Takes one input word per clock while not stalled and returns one result
// word for each after acceptance. The latency is set by the synchronous read
// of the value and mask memories, followed by the output register; scan
// state is updated in the cycle of acceptance, so consecutive scan samples
// never wait on each other. Two internal stages let one more word be taken
// while a result waits at the output. The stores come out of reset reading
// as zero through per-entry written flags, so there is no clearing pass and
// words are taken right after reset. Configuration writes are always ready
// and must be issued while no word is in flight.
// ----------------------------------------------------------------------------
module multitap_row_scan_responder_top
  import mrsr_pkg::*;
#(
  parameter int unsigned SOCKETS = 4,
  parameter int unsigned BANKS   = 3
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_valid_i,
  output      logic      cfg_ready_o,
  input  wire logic      cfg_index_i,
  input  wire logic [9:0] cfg_data_i,
  input  wire logic      in_valid_i,
  output      logic      in_stall_o,
  input  wire in_item_t  in_word_i,
  output      logic      out_valid_o,
  input  wire logic      out_stall_i,
  output      out_item_t out_word_o
);

  localparam int unsigned AddrW = $clog2(SOCKETS * WordsPerSocket);

  logic             accept;
  logic             s1_en;
  logic             out_en;
  logic             s1_valid_q;
  meta_t            s1_meta_q;
  meta_t            meta;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [31:0]      rd_val;
  logic [31:0]      rd_msk;
  logic             out_valid_q;
  out_item_t        out_q;
  out_item_t        out_d;

  // pipeline flow control
  assign out_en     = !out_valid_q || !out_stall_i;
  assign s1_en      = !s1_valid_q || out_en;
  assign in_stall_o = !s1_en;
  assign accept     = in_valid_i && s1_en;
  assign cfg_ready_o = 1'b1;

  mrsr_ctrl #(
    .Sockets (SOCKETS),
    .Banks   (BANKS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .item_i      (in_word_i),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .meta_o      (meta)
  );

  mrsr_store #(
    .Sockets (SOCKETS)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (accept),
    .wr_kind_i   (in_word_i.kind),
    .wr_socket_i (in_word_i.socket),
    .wr_index_i  (in_word_i.word_index),
    .wr_data_i   (in_word_i.word_value),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .rd_val_o    (rd_val),
    .rd_msk_o    (rd_msk)
  );

  // read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_meta_q <= meta;
    end
  end

  // form the driven word
  always_comb begin
    out_d.drive_valid  = s1_meta_q.drive_valid;
    out_d.stall_active = s1_meta_q.stall_active;
    out_d.frame_done   = s1_meta_q.frame_done;
    out_d.frame_socket = s1_meta_q.frame_socket;
    if (!s1_meta_q.drive_valid) begin
      out_d.drive_word = '0;
    end else if (s1_meta_q.idle) begin
      out_d.drive_word = IDLE_WORD;
    end else if (s1_meta_q.use_mask) begin
      out_d.drive_word = rd_val | rd_msk;
    end else begin
      out_d.drive_word = rd_val;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire
